>>> design/segi_pkg.sv
`default_nettype none
package segi_pkg;
  localparam logic [1:0] OUT_CROSS    = 2'd0;
  localparam logic [1:0] OUT_PARALLEL = 2'd1;
  localparam logic [1:0] OUT_MISS     = 2'd2;
  localparam int unsigned OUTCOME_BITS = 2;
endpackage
`default_nettype wire

>>> design/segi_prep.sv
`default_nettype none
// Front of the pipe: differences and the three cross products, two stages.
module segi_prep #(
  parameter int unsigned CB = 24
) (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire logic signed [CB-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1,
  output logic signed [2*CB+2:0]    den_o, sn_o, tn_o,
  output logic signed [CB:0]        dxa_o, dya_o,
  output logic signed [CB-1:0]      ax0_o, ay0_o
);
  localparam int unsigned DW = CB + 1;
  localparam int unsigned PW = 2*CB + 2;
  logic signed [DW-1:0] dxa_r, dya_r, dxb_r, dyb_r, sx_r, sy_r;
  logic signed [CB-1:0] ax0_r, ay0_r;
  logic signed [PW-1:0] p0, p1, p2, p3, p4, p5;
  always_ff @(posedge clk) begin
    if (en) begin
      dxa_r <= DW'(ax1) - DW'(ax0);
      dya_r <= DW'(ay1) - DW'(ay0);
      dxb_r <= DW'(bx1) - DW'(bx0);
      dyb_r <= DW'(by1) - DW'(by0);
      sx_r  <= DW'(ax0) - DW'(bx0);
      sy_r  <= DW'(ay0) - DW'(by0);
      ax0_r <= ax0;
      ay0_r <= ay0;
    end
  end
  assign p0 = PW'(dxa_r) * PW'(dyb_r);
  assign p1 = PW'(dxb_r) * PW'(dya_r);
  assign p2 = PW'(dxa_r) * PW'(sy_r);
  assign p3 = PW'(dya_r) * PW'(sx_r);
  assign p4 = PW'(dxb_r) * PW'(sy_r);
  assign p5 = PW'(dyb_r) * PW'(sx_r);
  always_ff @(posedge clk) begin
    if (en) begin
      den_o <= (PW+1)'(p0) - (PW+1)'(p1);
      sn_o  <= (PW+1)'(p2) - (PW+1)'(p3);
      tn_o  <= (PW+1)'(p4) - (PW+1)'(p5);
      dxa_o <= dxa_r;
      dya_o <= dya_r;
      ax0_o <= ax0_r;
      ay0_o <= ay0_r;
    end
  end
endmodule
`default_nettype wire

>>> design/segi_cell.sv
`default_nettype none
// One restoring-division step for x and y; carries the item to the next cell.
module segi_cell #(
  parameter int unsigned NW = 80,
  parameter int unsigned DW = 50,
  parameter int unsigned QW = 25,
  parameter int unsigned CB = 24,
  parameter int unsigned BIT = 0
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic [NW-1:0]        nx_i, ny_i,
  input  wire logic [DW-1:0]        d_i,
  input  wire logic [QW-1:0]        qx_i, qy_i,
  input  wire logic [1:0]           oc_i,
  input  wire logic                 negx_i, negy_i,
  input  wire logic signed [CB-1:0] x0_i, y0_i,
  output logic [NW-1:0]             nx_o, ny_o,
  output logic [DW-1:0]             d_o,
  output logic [QW-1:0]             qx_o, qy_o,
  output logic [1:0]                oc_o,
  output logic                      negx_o, negy_o,
  output logic signed [CB-1:0]      x0_o, y0_o
);
  logic [NW-1:0] dsh, nx_n, ny_n;
  logic          gx, gy;
  assign dsh  = NW'(d_i) << BIT;
  assign gx   = nx_i >= dsh;
  assign gy   = ny_i >= dsh;
  assign nx_n = gx ? nx_i - dsh : nx_i;
  assign ny_n = gy ? ny_i - dsh : ny_i;
  always_ff @(posedge clk) begin
    if (en) begin
      nx_o <= nx_n;
      ny_o <= ny_n;
      d_o  <= d_i;
      qx_o <= qx_i | (QW'(gx) << BIT);
      qy_o <= qy_i | (QW'(gy) << BIT);
      oc_o <= oc_i;
      negx_o <= negx_i;
      negy_o <= negy_i;
      x0_o <= x0_i;
      y0_o <= y0_i;
    end
  end
endmodule
`default_nettype wire

>>> design/segment_intersection.sv
`default_nettype none
// Segment intersection with exact integer cross products. Fully pipelined:
// one segment pair is taken every cycle while the pipe advances; the pipe ends
// in a row of division cells (one quotient bit per cell) that turns
// t_numer*dA/denom into the offset along segment A. The pipe advances whenever
// the output register is empty or being read, so in_tready follows out_tready.
module segment_intersection #(
  parameter int unsigned COORD_BITS = 24,
  parameter int unsigned FRAC_BITS  = 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
  input  wire logic [((8*COORD_BITS+7)/8)*8-1:0] in_tdata,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // outcome, cross_x, cross_y
  output logic [((2*COORD_BITS+2+7)/8)*8-1:0]  out_tdata
);
  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned PW = 2*CB + 3;
  localparam int unsigned DW = PW;
  localparam int unsigned QW = CB + 1;
  localparam int unsigned NW = DW + QW;
  localparam int unsigned NS = QW;
  localparam int unsigned LAT = 2 + 4 + NS;
  localparam int unsigned OW = ((2*CB+2+7)/8)*8;
  localparam int unsigned FB = FRAC_BITS;

  logic en;
  logic [LAT-1:0] vld_r;
  assign en        = !vld_r[LAT-1] || out_tready;
  assign in_tready = en;
  assign out_tvalid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[LAT-2:0], in_tvalid};
  end

  logic signed [PW-1:0] den, sn, tn;
  logic signed [CB:0]   dxa, dya;
  logic signed [CB-1:0] ax0, ay0;

  segi_prep #(.CB(CB)) u_prep (
    .clk(clk), .en(en),
    .ax0(in_tdata[0*CB +: CB]), .ay0(in_tdata[1*CB +: CB]),
    .ax1(in_tdata[2*CB +: CB]), .ay1(in_tdata[3*CB +: CB]),
    .bx0(in_tdata[4*CB +: CB]), .by0(in_tdata[5*CB +: CB]),
    .bx1(in_tdata[6*CB +: CB]), .by1(in_tdata[7*CB +: CB]),
    .den_o(den), .sn_o(sn), .tn_o(tn),
    .dxa_o(dxa), .dya_o(dya), .ax0_o(ax0), .ay0_o(ay0)
  );

  // stage 3: sign normalisation and range test
  logic [DW-1:0] d3_r, t3_r;
  logic [1:0]    oc3_r;
  logic [CB:0]   mx3_r, my3_r;
  logic          nx3_r, ny3_r;
  logic signed [CB-1:0] x3_r, y3_r;
  logic signed [PW-1:0] dn, sn_n, tn_n;
  logic [1:0] oc_nxt;
  always_comb begin
    dn   = den[PW-1] ? -den : den;
    sn_n = den[PW-1] ? -sn : sn;
    tn_n = den[PW-1] ? -tn : tn;
    if (den == '0) oc_nxt = segi_pkg::OUT_PARALLEL;
    else if (sn_n[PW-1] || tn_n[PW-1] || sn_n > dn || tn_n > dn)
      oc_nxt = segi_pkg::OUT_MISS;
    else oc_nxt = segi_pkg::OUT_CROSS;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      d3_r  <= dn;
      t3_r  <= (oc_nxt == segi_pkg::OUT_CROSS) ? tn_n : '0;
      oc3_r <= oc_nxt;
      mx3_r <= dxa[CB] ? -dxa : dxa;
      my3_r <= dya[CB] ? -dya : dya;
      nx3_r <= dxa[CB];
      ny3_r <= dya[CB];
      x3_r  <= ax0;
      y3_r  <= ay0;
    end
  end

  // stage 4: t * |dA| as two partial products, low and high part of t
  logic [2*QW-1:0] plx4_r, ply4_r;
  logic [DW-1:0]   phx4_r, phy4_r;
  logic [DW-1:0]   d4_r;
  logic [1:0]      oc4_r;
  logic            nx4n_r, ny4n_r;
  logic signed [CB-1:0] x4_r, y4_r;
  always_ff @(posedge clk) begin
    if (en) begin
      plx4_r <= (2*QW)'(t3_r[QW-1:0]) * (2*QW)'(mx3_r);
      ply4_r <= (2*QW)'(t3_r[QW-1:0]) * (2*QW)'(my3_r);
      phx4_r <= DW'(t3_r[DW-1:QW]) * DW'(mx3_r);
      phy4_r <= DW'(t3_r[DW-1:QW]) * DW'(my3_r);
      d4_r  <= (oc3_r == segi_pkg::OUT_CROSS) ? d3_r : DW'(1);
      oc4_r <= oc3_r;
      nx4n_r <= nx3_r;
      ny4n_r <= ny3_r;
      x4_r <= x3_r;
      y4_r <= y3_r;
    end
  end

  // stage 5: sum of the partial products (numerator below denom * 2^QW)
  logic [NW-1:0] nx5_r, ny5_r;
  logic [DW-1:0] d5_r;
  logic [1:0]    oc5_r;
  logic          nx5n_r, ny5n_r;
  logic signed [CB-1:0] x5_r, y5_r;
  always_ff @(posedge clk) begin
    if (en) begin
      nx5_r <= (NW'(phx4_r) << QW) + NW'(plx4_r);
      ny5_r <= (NW'(phy4_r) << QW) + NW'(ply4_r);
      d5_r  <= d4_r;
      oc5_r <= oc4_r;
      nx5n_r <= nx4n_r;
      ny5n_r <= ny4n_r;
      x5_r <= x4_r;
      y5_r <= y4_r;
    end
  end

  // division row, most significant quotient bit first
  logic [NW-1:0] cnx [NS+1];
  logic [NW-1:0] cny [NS+1];
  logic [DW-1:0] cd  [NS+1];
  logic [QW-1:0] cqx [NS+1];
  logic [QW-1:0] cqy [NS+1];
  logic [1:0]    coc [NS+1];
  logic          cngx [NS+1];
  logic          cngy [NS+1];
  logic signed [CB-1:0] cx0 [NS+1];
  logic signed [CB-1:0] cy0 [NS+1];
  assign cnx[0] = nx5_r;
  assign cny[0] = ny5_r;
  assign cd[0]  = d5_r;
  assign cqx[0] = '0;
  assign cqy[0] = '0;
  assign coc[0] = oc5_r;
  assign cngx[0] = nx5n_r;
  assign cngy[0] = ny5n_r;
  assign cx0[0] = x5_r;
  assign cy0[0] = y5_r;

  for (genvar i = 0; i < NS; i++) begin : g_cell
    segi_cell #(.NW(NW), .DW(DW), .QW(QW), .CB(CB), .BIT(NS-1-i)) u_cell (
      .clk(clk), .en(en),
      .nx_i(cnx[i]), .ny_i(cny[i]), .d_i(cd[i]), .qx_i(cqx[i]), .qy_i(cqy[i]),
      .oc_i(coc[i]), .negx_i(cngx[i]), .negy_i(cngy[i]), .x0_i(cx0[i]), .y0_i(cy0[i]),
      .nx_o(cnx[i+1]), .ny_o(cny[i+1]), .d_o(cd[i+1]), .qx_o(cqx[i+1]),
      .qy_o(cqy[i+1]), .oc_o(coc[i+1]), .negx_o(cngx[i+1]), .negy_o(cngy[i+1]),
      .x0_o(cx0[i+1]), .y0_o(cy0[i+1])
    );
  end

  // output register
  logic [CB-1:0] ox, oy;
  logic [1:0]    ocf;
  logic [OW-1:0] od_r;
  always_comb begin
    ocf = coc[NS];
    if (ocf == segi_pkg::OUT_CROSS) begin
      ox = cngx[NS] ? cx0[NS] - CB'(cqx[NS]) : cx0[NS] + CB'(cqx[NS]);
      oy = cngy[NS] ? cy0[NS] - CB'(cqy[NS]) : cy0[NS] + CB'(cqy[NS]);
    end else begin
      ox = '0;
      oy = '0;
    end
  end
  always_ff @(posedge clk) begin
    if (en) od_r <= OW'({oy, ox, ocf});
  end
  assign out_tdata = od_r;

  // Q format only affects interpretation; keep it visible in the fraction width
  logic unused_frac;
  assign unused_frac = (FB > CB);
endmodule
`default_nettype wire

>>> design/segi_checker.sv
`default_nettype none
module segi_checker #(
  parameter int unsigned CB = 24
) (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_tready,
  input wire logic                             out_tvalid,
  input wire logic                             out_tready,
  input wire logic [((2*CB+2+7)/8)*8-1:0]      out_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)) else $error("hold");
  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] <= segi_pkg::OUT_MISS) else $error("code");
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != segi_pkg::OUT_CROSS |-> out_tdata[2*CB+1:2] == '0)
    else $error("zero");
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready) else $error("ready");
endmodule
bind segment_intersection segi_checker #(.CB(COORD_BITS)) u_chk (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
`default_nettype wire
